// ===== hw/rtl/srdiv_pkg.sv =====
// Shared types and constants for the scaled rounding divider
package srdiv_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned WideW = 64;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DELTA_SCALE = 2'd0,
        REG_EPS_OFFSET  = 2'd1,
        REG_ETA_SCALE   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             vld;
        logic             neg;
        logic             dz;
        logic [WideW-1:0] rem;
        logic [WideW-1:0] dvd;
        logic [WideW-1:0] dsr;
    } div_word_t;

endpackage

// ===== hw/rtl/scaled_rounding_divider_top.sv =====
// Top level of the scaled rounding divider: config registers, pipeline, output word
// Throughput: one word per cycle while the output is not stalled; 5 scaling stages, 64 divide stages, 1 output stage.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and sets delta_scale=1, eps_offset=0, eta_scale=1.
module scaled_rounding_divider_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [srdiv_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [srdiv_pkg::DataW-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [srdiv_pkg::DataW-1:0]   numerator,
    input  logic signed [srdiv_pkg::DataW-1:0]   denominator,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [srdiv_pkg::DataW-1:0]   quotient,
    output logic                                 div_by_zero
);
    localparam int unsigned W = srdiv_pkg::WideW;
    localparam int unsigned H = srdiv_pkg::DataW;

    logic signed [H-1:0] delta_reg, eps_reg, eta_reg;
    logic                stall, adv;
    srdiv_pkg::div_word_t div_w [0:W];
    logic [W-1:0]        qs;
    logic                ovld_reg, odz_reg;
    logic [H-1:0]        oq_reg;

    assign stall    = ovld_reg && !out_ready;
    assign adv      = !stall;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= H'(1);
            eps_reg   <= '0;
            eta_reg   <= H'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                srdiv_pkg::REG_DELTA_SCALE: delta_reg <= cfg_data;
                srdiv_pkg::REG_EPS_OFFSET:  eps_reg   <= cfg_data;
                srdiv_pkg::REG_ETA_SCALE:   eta_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    srdiv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (in_valid),
        .num    (numerator),
        .den    (denominator),
        .delta  (delta_reg),
        .eps    (eps_reg),
        .eta    (eta_reg),
        .word   (div_w[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_step
        srdiv_step u_step (
            .clk  (clk),
            .rst_n(rst_n),
            .adv  (adv),
            .din  (div_w[i]),
            .dout (div_w[i+1])
        );
    end

    assign qs = div_w[W].neg ? W'(0) - div_w[W].dvd : div_w[W].dvd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (adv)
            ovld_reg <= div_w[W].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oq_reg  <= div_w[W].dz ? '0 : qs[H-1:0];
            odz_reg <= div_w[W].dz;
        end
    end

    assign out_valid   = ovld_reg;
    assign quotient    = oq_reg;
    assign div_by_zero = odz_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> (quotient == '0))
        else $error("zero divisor word with nonzero quotient");

    a_front_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (div_w[0].vld && div_w[0].dz) |-> (div_w[0].dsr == '0))
        else $error("zero flag set with nonzero divisor magnitude");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> ($stable(div_w[W].dvd) && $stable(div_w[0].dvd)))
        else $error("pipeline moved during stall");

endmodule

// ===== hw/rtl/srdiv_front.sv =====
// Scaling, rounding offset and sign split ahead of the divider
module srdiv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_vld,
    input  logic signed [srdiv_pkg::DataW-1:0] num,
    input  logic signed [srdiv_pkg::DataW-1:0] den,
    input  logic signed [srdiv_pkg::DataW-1:0] delta,
    input  logic signed [srdiv_pkg::DataW-1:0] eps,
    input  logic signed [srdiv_pkg::DataW-1:0] eta,
    output srdiv_pkg::div_word_t             word
);
    localparam int unsigned W = srdiv_pkg::WideW;
    localparam int unsigned H = srdiv_pkg::DataW;

    logic [3:0]        vld_reg;
    logic signed [W-1:0] p1_reg, dm1_reg;
    logic [H-1:0]      num1_reg, eps1_reg;
    logic [W-1:0]      m0_reg, d2_reg;
    logic [H-1:0]      m1_reg, corr_reg;
    logic [W-1:0]      n3_reg, d3_reg, half3_reg;
    logic              dz3_reg;
    logic [W-1:0]      a4_reg, d4_reg;
    logic              dz4_reg;
    srdiv_pkg::div_word_t word_reg;

    logic signed [W-1:0] p_next, dm_next;
    logic [W-1:0]      m0_next, d2_next, n3_next, a4_next, amag, dmag;
    logic [H-1:0]      m1_next;

    assign p_next  = W'(delta) * W'(eta);
    assign dm_next = W'(eta) * W'(den);
    assign m0_next = W'(p1_reg[H-1:0]) * W'(num1_reg);
    assign m1_next = H'(p1_reg[W-1:H] * num1_reg);
    assign d2_next = dm1_reg + {{H{eps1_reg[H-1]}}, eps1_reg};
    assign n3_next = m0_reg + {m1_reg - corr_reg, {H{1'b0}}};
    assign a4_next = n3_reg[W-1] ? n3_reg - half3_reg : n3_reg + half3_reg;
    assign amag    = a4_reg[W-1] ? W'(0) - a4_reg : a4_reg;
    assign dmag    = d4_reg[W-1] ? W'(0) - d4_reg : d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            word_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[2:0], in_vld};
            word_reg.vld  <= vld_reg[3];
            word_reg.neg  <= a4_reg[W-1] ^ d4_reg[W-1];
            word_reg.dz   <= dz4_reg;
            word_reg.rem  <= '0;
            word_reg.dvd  <= amag;
            word_reg.dsr  <= dmag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg        <= p_next;
            dm1_reg       <= dm_next;
            num1_reg      <= num;
            eps1_reg      <= eps;
            m0_reg        <= m0_next;
            m1_reg        <= m1_next;
            corr_reg      <= num1_reg[H-1] ? p1_reg[H-1:0] : '0;
            d2_reg        <= d2_next;
            n3_reg        <= n3_next;
            d3_reg        <= d2_reg;
            half3_reg     <= {d2_reg[W-1], d2_reg[W-1:1]};
            dz3_reg       <= (d2_reg == '0);
            a4_reg        <= a4_next;
            d4_reg        <= d3_reg;
            dz4_reg       <= dz3_reg;
        end
    end

    assign word = word_reg;

endmodule

// ===== hw/rtl/srdiv_step.sv =====
// One restoring division step: one quotient bit per stage
module srdiv_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  srdiv_pkg::div_word_t din,
    output srdiv_pkg::div_word_t dout
);
    localparam int unsigned W = srdiv_pkg::WideW;

    srdiv_pkg::div_word_t word_reg;
    logic [W:0]   sh;
    logic         ge;
    logic [W:0]   diff;

    assign sh   = {din.rem, din.dvd[W-1]};
    assign ge   = sh >= {1'b0, din.dsr};
    assign diff = sh - {1'b0, din.dsr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else if (adv)
        begin
            word_reg.vld <= din.vld;
            word_reg.neg <= din.neg;
            word_reg.dz  <= din.dz;
            word_reg.dsr <= din.dsr;
            word_reg.rem <= ge ? diff[W-1:0] : sh[W-1:0];
            word_reg.dvd <= {din.dvd[W-2:0], ge};
        end
    end

    assign dout = word_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the scaled rounding divider: directed table, extreme scales, then random words
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned RANDOM_WORDS = 1400;
    localparam int unsigned DRAIN_CYCLES = 100;

    typedef struct {
        logic [srdiv_pkg::DataW-1:0] quo;
        logic                        dz;
    } quo_word_t;

    typedef struct {
        logic [srdiv_pkg::DataW-1:0] num;
        logic [srdiv_pkg::DataW-1:0] den;
        logic                        known;
        logic [srdiv_pkg::DataW-1:0] quo;
        logic                        dz;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [srdiv_pkg::CfgIdxW-1:0]       cfg_index;
    logic [srdiv_pkg::DataW-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [srdiv_pkg::DataW-1:0]  numerator;
    logic signed [srdiv_pkg::DataW-1:0]  denominator;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [srdiv_pkg::DataW-1:0]  quotient;
    logic                                div_by_zero;

    logic [srdiv_pkg::WideW-1:0] delta_m;
    logic [srdiv_pkg::WideW-1:0] eps_m;
    logic [srdiv_pkg::WideW-1:0] eta_m;

    quo_word_t   pending_q[$];
    int unsigned cycles;
    int unsigned errors;
    bit          hold_go;
    bit          hold_off;

    scaled_rounding_divider_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .numerator(numerator), .denominator(denominator),
        .out_valid(out_valid), .out_ready(out_ready),
        .quotient(quotient), .div_by_zero(div_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [srdiv_pkg::WideW-1:0] sext(logic [srdiv_pkg::DataW-1:0] v);
        return {{(srdiv_pkg::WideW-srdiv_pkg::DataW){v[srdiv_pkg::DataW-1]}}, v};
    endfunction

    function automatic logic [srdiv_pkg::WideW-1:0] mag(logic [srdiv_pkg::WideW-1:0] v);
        return v[srdiv_pkg::WideW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic quo_word_t rounded_quotient(logic [srdiv_pkg::DataW-1:0] num,
                                                   logic [srdiv_pkg::DataW-1:0] den);
        logic [srdiv_pkg::WideW-1:0] n;
        logic [srdiv_pkg::WideW-1:0] d;
        logic [srdiv_pkg::WideW-1:0] half;
        logic [srdiv_pkg::WideW-1:0] a;
        logic [srdiv_pkg::WideW-1:0] q;
        quo_word_t r;
        n = delta_m * eta_m * sext(num);
        d = eta_m * sext(den) + eps_m;
        if (d == '0)
        begin
            r.quo = '0;
            r.dz = 1'b1;
            return r;
        end
        half = {d[srdiv_pkg::WideW-1], d[srdiv_pkg::WideW-1:1]};
        a = n[srdiv_pkg::WideW-1] ? (n - half) : (n + half);
        q = mag(a) / mag(d);
        if (a[srdiv_pkg::WideW-1] != d[srdiv_pkg::WideW-1])
            q = ~q + 1'b1;
        r.quo = q[srdiv_pkg::DataW-1:0];
        r.dz = 1'b0;
        return r;
    endfunction

    function automatic logic [srdiv_pkg::DataW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(srdiv_pkg::cfg_reg_t idx, logic [srdiv_pkg::DataW-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            srdiv_pkg::REG_DELTA_SCALE: delta_m = sext(value);
            srdiv_pkg::REG_EPS_OFFSET:  eps_m   = sext(value);
            srdiv_pkg::REG_ETA_SCALE:   eta_m   = sext(value);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_word(logic [srdiv_pkg::DataW-1:0] num, logic [srdiv_pkg::DataW-1:0] den,
                             logic known, logic [srdiv_pkg::DataW-1:0] quo, logic dz);
        quo_word_t e;
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(posedge clk);
        end
        e = rounded_quotient(num, den);
        if (known && e.quo !== quo)
        begin
            $error("table quotient expected %h actual %h", quo, e.quo);
            errors++;
        end
        if (known && e.dz !== dz)
        begin
            $error("table div_by_zero expected %b actual %b", dz, e.dz);
            errors++;
        end
        in_valid    <= 1'b1;
        numerator   <= num;
        denominator <= den;
        pending_q.push_back(e);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int unsigned count);
        repeat (count) send_word(pick_value(), pick_value(), 1'b0, '0, 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected word quotient=%h div_by_zero=%b", quotient, div_by_zero);
                errors++;
            end
            else
            begin
                quo_word_t e;
                e = pending_q.pop_front();
                if (quotient !== e.quo)
                begin
                    $error("quotient expected %h actual %h", e.quo, quotient);
                    errors++;
                end
                if (div_by_zero !== e.dz)
                begin
                    $error("div_by_zero expected %b actual %b", e.dz, div_by_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 4) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (hold_go);
        repeat (20) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        errors = 0;
        hold_go = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        numerator = '0;
        denominator = '0;
        delta_m = 64'd1;
        eps_m = '0;
        eta_m = 64'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset scales: plain rounded division
        rows = '{
            '{32'd7, 32'd2, 1'b1, 32'd4, 1'b0},
            '{-32'sd7, 32'd2, 1'b1, -32'sd4, 1'b0},
            '{32'd5, 32'd0, 1'b1, 32'd0, 1'b1},
            '{32'd0, 32'd5, 1'b1, 32'd0, 1'b0},
            '{32'd1, 32'd3, 1'b1, 32'd0, 1'b0},
            '{32'd3, -32'sd2, 1'b1, -32'sd1, 1'b0},
            '{32'h7fff_ffff, 32'd1, 1'b1, 32'h7fff_ffff, 1'b0},
            '{32'h8000_0000, 32'd1, 1'b1, 32'h8000_0000, 1'b0},
            '{32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, 1'b0},
            '{32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'd0, 1'b0},
            '{32'hffff_ffff, 32'h7fff_ffff, 1'b1, 32'd0, 1'b0},
            '{32'h1234_5678, 32'h0000_0100, 1'b0, '0, 1'b0},
            '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'd0, 1'b0}
        };
        foreach (rows[i])
            send_word(rows[i].num, rows[i].den, rows[i].known, rows[i].quo, rows[i].dz);
        wait_idle();

        // extreme scales: wrap, overflowing division and offset zeroing the divisor
        write_reg(srdiv_pkg::REG_DELTA_SCALE, 32'h8000_0000);
        write_reg(srdiv_pkg::REG_ETA_SCALE, 32'h8000_0000);
        write_reg(srdiv_pkg::REG_EPS_OFFSET, 32'h7fff_ffff);
        send_word(32'h8000_0000, 32'h7fff_ffff, 1'b0, '0, 1'b0);
        send_word(32'h7fff_ffff, 32'h0000_0001, 1'b0, '0, 1'b0);
        send_word(32'h0000_0002, 32'hffff_ffff, 1'b0, '0, 1'b0);
        wait_idle();
        write_reg(srdiv_pkg::REG_DELTA_SCALE, 32'd1);
        write_reg(srdiv_pkg::REG_ETA_SCALE, 32'd1);
        write_reg(srdiv_pkg::REG_EPS_OFFSET, 32'hffff_fffe);
        send_word(32'd9, 32'd2, 1'b1, 32'd0, 1'b1);
        send_word(32'd9, 32'd3, 1'b1, 32'd9, 1'b0);
        wait_idle();
        write_reg(srdiv_pkg::REG_ETA_SCALE, 32'h7fff_ffff);
        write_reg(srdiv_pkg::REG_DELTA_SCALE, 32'h7fff_ffff);
        write_reg(srdiv_pkg::REG_EPS_OFFSET, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0);
        send_word(32'h7fff_ffff, 32'h0000_0000, 1'b0, '0, 1'b0);
        wait_idle();

        for (int p = 0; p < 7; p++)
        begin
            write_reg(srdiv_pkg::REG_DELTA_SCALE, pick_value());
            write_reg(srdiv_pkg::REG_EPS_OFFSET, (p % 2) ? 32'd0 : pick_value());
            write_reg(srdiv_pkg::REG_ETA_SCALE, (p == 0) ? 32'd1 : pick_value());
            if (p == 1)
                hold_go = 1'b1;
            random_phase(RANDOM_WORDS / 7);
            wait_idle();
        end

        if (errors == 0 && pending_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/srdiv_pkg.sv
hw/rtl/srdiv_front.sv
hw/rtl/srdiv_step.sv
hw/rtl/scaled_rounding_divider_top.sv
tb/tb.sv
